@@ design/lppd_pkg.sv @@
// Package for the length-prefixed packet deframer.
// Holds the parser phase type, the header type codes, the result record and queue sizing.
// Depends on nothing; every other design file imports it.
package lppd_pkg;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN8,
    PH_LEN16HI,
    PH_LEN16LO,
    PH_BODY,
    PH_DEAD
  } phase_t;

  // Type bytes that open a packet.
  localparam logic [7:0] TYPE_SHORT_A = 8'hC1;
  localparam logic [7:0] TYPE_SHORT_B = 8'hC3;
  localparam logic [7:0] TYPE_LONG_A  = 8'hC2;
  localparam logic [7:0] TYPE_LONG_B  = 8'hC4;

  // Header sizes, which are also the smallest legal total lengths.
  localparam logic [15:0] HDR_SHORT_LEN = 16'd2;
  localparam logic [15:0] HDR_LONG_LEN  = 16'd3;

  localparam int MaxResults = 3;
  localparam int QueueDepth = 4;
  localparam int CountW     = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       err;
  } result_t;

  // Everything one input byte produces.
  typedef struct packed {
    logic [1:0]                   count;
    result_t [MaxResults-1:0]     item;
  } step_t;

endpackage

@@ design/lppd_parser.sv @@
// Header parser of the deframer: phase register, held header bytes and body counter.
// Turns one accepted byte into zero to three results. Depends on lppd_pkg.
module lppd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  output lppd_pkg::step_t step
);
  import lppd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_length_high, held_length_high_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;

  logic [15:0] len_short, len_long;
  logic        body_ends;

  assign len_short = {8'd0, data_byte};
  assign len_long  = {held_length_high, data_byte};
  assign body_ends = (bytes_remaining <= 16'd1);

  // Next state.
  always_comb begin
    phase_next            = phase;
    held_type_next        = held_type;
    held_length_high_next = held_length_high;
    bytes_remaining_next  = bytes_remaining;
    if (take) begin
      case (phase)
        PH_TYPE: begin
          if (data_byte inside {TYPE_SHORT_A, TYPE_SHORT_B}) begin
            held_type_next = data_byte;
            phase_next     = PH_LEN8;
          end else if (data_byte inside {TYPE_LONG_A, TYPE_LONG_B}) begin
            held_type_next = data_byte;
            phase_next     = PH_LEN16HI;
          end
        end
        PH_LEN8: begin
          if (len_short < HDR_SHORT_LEN) begin
            phase_next = PH_DEAD;
          end else if (len_short == HDR_SHORT_LEN) begin
            phase_next = PH_TYPE;
          end else begin
            bytes_remaining_next = len_short - HDR_SHORT_LEN;
            phase_next           = PH_BODY;
          end
        end
        PH_LEN16HI: begin
          held_length_high_next = data_byte;
          phase_next            = PH_LEN16LO;
        end
        PH_LEN16LO: begin
          if (len_long < HDR_LONG_LEN) begin
            phase_next = PH_DEAD;
          end else if (len_long == HDR_LONG_LEN) begin
            phase_next = PH_TYPE;
          end else begin
            bytes_remaining_next = len_long - HDR_LONG_LEN;
            phase_next           = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_ends) begin
            bytes_remaining_next = '0;
            phase_next           = PH_TYPE;
          end else begin
            bytes_remaining_next = bytes_remaining - 16'd1;
          end
        end
        default: begin
          phase_next = PH_DEAD;
        end
      endcase
    end
  end

  // Results of the byte being taken.
  always_comb begin
    step = '0;
    if (take) begin
      case (phase)
        PH_LEN8: begin
          if (len_short < HDR_SHORT_LEN) begin
            step.count   = 2'd1;
            step.item[0] = '{data: 8'd0, first: 1'b0, last: 1'b0, err: 1'b1};
          end else begin
            step.count   = 2'd2;
            step.item[0] = '{data: held_type, first: 1'b1, last: 1'b0, err: 1'b0};
            step.item[1] = '{data: data_byte, first: 1'b0,
                             last: (len_short == HDR_SHORT_LEN), err: 1'b0};
          end
        end
        PH_LEN16LO: begin
          if (len_long < HDR_LONG_LEN) begin
            step.count   = 2'd1;
            step.item[0] = '{data: 8'd0, first: 1'b0, last: 1'b0, err: 1'b1};
          end else begin
            step.count   = 2'd3;
            step.item[0] = '{data: held_type, first: 1'b1, last: 1'b0, err: 1'b0};
            step.item[1] = '{data: held_length_high, first: 1'b0, last: 1'b0,
                             err: 1'b0};
            step.item[2] = '{data: data_byte, first: 1'b0,
                             last: (len_long == HDR_LONG_LEN), err: 1'b0};
          end
        end
        PH_BODY: begin
          step.count   = 2'd1;
          step.item[0] = '{data: data_byte, first: 1'b0, last: body_ends, err: 1'b0};
        end
        default: begin
          step = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TYPE;
      held_type        <= '0;
      held_length_high <= '0;
      bytes_remaining  <= '0;
    end else begin
      phase            <= phase_next;
      held_type        <= held_type_next;
      held_length_high <= held_length_high_next;
      bytes_remaining  <= bytes_remaining_next;
    end
  end

`ifndef ASSERT_OFF
  // A framing error kills the stream until reset.
  a_dead_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEAD |=> phase == PH_DEAD)
    else $error("parser left the dead phase without reset");

  // The error result is always alone.
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    (step.count != 2'd0 && step.item[0].err) |-> step.count == 2'd1)
    else $error("error result shares a step with other results");

  // Nothing comes out of the dead phase.
  a_dead_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEAD |-> step.count == 2'd0)
    else $error("dead stream produced a result");
`endif

endmodule

@@ design/lppd_outq.sv @@
// Output queue of the deframer: a short shift queue of results, head at slot zero.
// Takes up to three results at once and hands out one per transfer. Depends on lppd_pkg.
module lppd_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lppd_pkg::step_t   step,
  output logic              room,
  input  logic              m_ready,
  output logic              m_valid,
  output lppd_pkg::result_t head
);
  import lppd_pkg::*;

  result_t           q [QueueDepth];
  result_t           q_next [QueueDepth];
  logic [CountW-1:0] count, count_next, base;
  logic              pop;

  assign m_valid = (count != '0);
  assign head    = q[0];
  assign pop     = m_valid & m_ready;
  assign base    = count - {{(CountW-1){1'b0}}, pop};
  // A new step may add up to the largest result count.
  assign room    = (base <= CountW'(QueueDepth - MaxResults));

  always_comb begin
    for (int i = 0; i < QueueDepth - 1; i++) begin
      q_next[i] = pop ? q[i+1] : q[i];
    end
    q_next[QueueDepth-1] = q[QueueDepth-1];
    if (push) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (CountW'(i) >= base &&
            (CountW'(i) - base) < {{(CountW-2){1'b0}}, step.count}) begin
          q_next[i] = step.item[2'(CountW'(i) - base)];
        end
      end
    end
    count_next = base + (push ? {{(CountW-2){1'b0}}, step.count} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(QueueDepth))
    else $error("output queue overfilled");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(count))
    else $error("queue count moved with no push or pop");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> (base + {{(CountW-2){1'b0}}, step.count}) <= CountW'(QueueDepth))
    else $error("push without room for its results");
`endif

endmodule

@@ design/length_prefixed_packet_deframer_unit.sv @@
// Top level of the length-prefixed packet deframer.
// Joins the header parser and the output queue. Depends on lppd_pkg, lppd_parser, lppd_outq.
//
// Usage: received bytes enter on the slave stream (s_tvalid, s_tready, s_tdata), one byte
// per transfer. Packets leave on the master stream, one byte per transfer, with tuser bit 0
// marking the type byte that opens a packet, tlast marking the byte that ends it, and
// tuser bit 1 marking the single error result (data zero) sent on a bad length.
// Type bytes C1/C3 take a one-byte length, C2/C4 a two-byte big-endian length; the length
// counts the header. Other bytes in the type position are dropped. After a framing error
// every byte is taken and dropped until reset.
// Results are registered in the output queue when the byte that causes them is taken.
// Throughput: body bytes flow at one per cycle while the master side takes them. A header
// release puts two or three results into a four-entry output queue at once. With the
// master side taking a result every cycle, a three-result release (two-byte length) holds
// s_tready low while the queue drains, and a two-result release (one-byte length) causes no
// stall; that queue's depth and the master side's one result per cycle set the rate.
// The slave side keeps taking bytes while a result waits on a stalled master side, as
// long as the queue has room for the worst case of three results.
// Reset (rst, synchronous, active high) empties the queue and returns the parser to
// waiting for a type byte.
module length_prefixed_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_packet
  output logic [1:0] m_tuser    // [0] first_of_packet, [1] framing_error
);
  import lppd_pkg::*;

  logic    take;
  logic    room;
  step_t   step;
  result_t head;

  // A byte is taken only when the queue can hold everything it may produce.
  assign s_tready = room;
  assign take     = s_tvalid & room;

  lppd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .step      (step)
  );

  lppd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (take),
    .step    (step),
    .room    (room),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .head    (head)
  );

  assign m_tdata = head.data;
  assign m_tlast = head.last;
  assign m_tuser = {head.err, head.first};

`ifndef ASSERT_OFF
  // An error result never also opens or closes a packet.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (!m_tlast && !m_tuser[0] && m_tdata == 8'd0))
    else $error("error result carries packet marks");

  // After an error result is transferred, nothing else ever comes out.
  a_err_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[1]) |=> !m_tvalid)
    else $error("result after framing error");

  // The slave side is never blocked while the output side is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty queue");
`endif

endmodule

@@ test/length_prefixed_packet_deframer_unit_tb.sv @@
// Self-checking testbench for length_prefixed_packet_deframer_unit.
// Drives byte streams with bursty transfers and random output stalls, and checks each output
// transfer against a packet parser kept in the bench. Depends on lppd_pkg and the design top.
module length_prefixed_packet_deframer_unit_tb;
  import lppd_pkg::*;

  localparam int ItemsTarget = 150;
  localparam int TailItems   = 20;
  localparam int LimitCycles = 3_000_000;
  localparam int DrainCycles = 16;
  localparam int MaxReports  = 10;

  // One output transfer as the parser sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       err;
  } pkt_byte_t;

  // One row of the directed table. When known is set, the row carries its own outputs.
  typedef struct packed {
    logic [7:0]      b;
    logic            known;
    logic [1:0]      n;
    pkt_byte_t [2:0] r;
  } stim_row_t;

  localparam pkt_byte_t NoByte = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  length_prefixed_packet_deframer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Parser state kept by the bench.
  phase_t      pr_phase = PH_TYPE;
  logic [7:0]  pr_type = 8'h00;
  logic [7:0]  pr_len_hi = 8'h00;
  logic [15:0] pr_left = 16'h0000;

  pkt_byte_t   pending_bytes[$];
  int          fail_cnt = 0;
  int          cyc = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  pkt_byte_t   got_byte;
  pkt_byte_t   want_byte;
  stim_row_t   dir_tab [24];

  function automatic pkt_byte_t mk_byte(input logic [7:0] d, input logic f, input logic l,
                                        input logic e);
    return {d, f, l, e};
  endfunction

  function automatic stim_row_t mk_row(input logic [7:0] b, input logic known,
                                       input logic [1:0] n, input pkt_byte_t r0,
                                       input pkt_byte_t r1, input pkt_byte_t r2);
    stim_row_t row;
    row.b = b;
    row.known = known;
    row.n = n;
    row.r = {r2, r1, r0};
    return row;
  endfunction

  // Advances the parser by one accepted byte and returns what it releases.
  task automatic parse_byte(input logic [7:0] b, output int n, output pkt_byte_t [2:0] r);
    logic [15:0] len;
    n = 0;
    r = '0;
    len = {8'h00, b};
    case (pr_phase)
      PH_TYPE: begin
        if (b == TYPE_SHORT_A || b == TYPE_SHORT_B) begin
          pr_type = b;
          pr_phase = PH_LEN8;
        end else if (b == TYPE_LONG_A || b == TYPE_LONG_B) begin
          pr_type = b;
          pr_phase = PH_LEN16HI;
        end
      end
      PH_LEN8: begin
        if (len < HDR_SHORT_LEN) begin
          r[0] = mk_byte(8'h00, 1'b0, 1'b0, 1'b1);
          n = 1;
          pr_phase = PH_DEAD;
        end else begin
          r[0] = mk_byte(pr_type, 1'b1, 1'b0, 1'b0);
          r[1] = mk_byte(b, 1'b0, len == HDR_SHORT_LEN, 1'b0);
          n = 2;
          pr_left = len - HDR_SHORT_LEN;
          pr_phase = (len == HDR_SHORT_LEN) ? PH_TYPE : PH_BODY;
        end
      end
      PH_LEN16HI: begin
        pr_len_hi = b;
        pr_phase = PH_LEN16LO;
      end
      PH_LEN16LO: begin
        len = {pr_len_hi, b};
        if (len < HDR_LONG_LEN) begin
          r[0] = mk_byte(8'h00, 1'b0, 1'b0, 1'b1);
          n = 1;
          pr_phase = PH_DEAD;
        end else begin
          r[0] = mk_byte(pr_type, 1'b1, 1'b0, 1'b0);
          r[1] = mk_byte(pr_len_hi, 1'b0, 1'b0, 1'b0);
          r[2] = mk_byte(b, 1'b0, len == HDR_LONG_LEN, 1'b0);
          n = 3;
          pr_left = len - HDR_LONG_LEN;
          pr_phase = (len == HDR_LONG_LEN) ? PH_TYPE : PH_BODY;
        end
      end
      PH_BODY: begin
        if (pr_left <= 16'd1) begin
          pr_left = 16'd0;
          r[0] = mk_byte(b, 1'b0, 1'b1, 1'b0);
          pr_phase = PH_TYPE;
        end else begin
          pr_left = pr_left - 16'd1;
          r[0] = mk_byte(b, 1'b0, 1'b0, 1'b0);
        end
        n = 1;
      end
      default: pr_phase = PH_DEAD;
    endcase
  endtask

  // Offers one byte, holding tvalid through bursts and dropping it for random gaps.
  // Once the transfer happens, the released bytes join the queue of pending bytes.
  task automatic send_row(input stim_row_t row);
    int n;
    pkt_byte_t [2:0] r;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    parse_byte(row.b, n, r);
    if (row.known) begin
      n = row.n;
      r = row.r;
    end
    for (int k = 0; k < n; k++) pending_bytes.push_back(r[k]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_row(mk_row(b, 1'b0, 2'd0, NoByte, NoByte, NoByte));
  endtask

  // Sends a whole packet: type, length and a random body.
  task automatic send_packet(input logic [7:0] kind, input logic [15:0] len);
    int body;
    send_byte(kind);
    if (kind == TYPE_SHORT_A || kind == TYPE_SHORT_B) begin
      send_byte(len[7:0]);
      body = len - HDR_SHORT_LEN;
    end else begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      body = len - HDR_LONG_LEN;
    end
    for (int k = 0; k < body; k++) send_byte($urandom_range(0, 255));
  endtask

  // Holds the sender off until every pending byte has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_type(input int sel);
    case (sel)
      0:       return TYPE_SHORT_A;
      1:       return TYPE_SHORT_B;
      2:       return TYPE_LONG_A;
      default: return TYPE_LONG_B;
    endcase
  endfunction

  // Output stall pattern, its character chosen by bits 10 and 9 of the cycle counter; also the run limit.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[10:9])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= (cyc % 3) != 0;
      2'd2:    m_tready <= $urandom_range(0, 2) != 0;
      default: m_tready <= cyc[5:3] != 3'd0;
    endcase
    if (cyc >= LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Each output transfer is matched against the oldest pending byte.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_byte = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
      if (pending_bytes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("cycle %0d: unexpected output data %02h first %b last %b err %b", cyc,
                   got_byte.data, got_byte.first, got_byte.last, got_byte.err);
      end else begin
        want_byte = pending_bytes.pop_front();
        if (got_byte.data !== want_byte.data || got_byte.first !== want_byte.first ||
            got_byte.last !== want_byte.last || got_byte.err !== want_byte.err) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("cycle %0d: expected %02h/%b/%b/%b, got %02h/%b/%b/%b (data/first/last/err)",
                     cyc, want_byte.data, want_byte.first, want_byte.last, want_byte.err,
                     got_byte.data, got_byte.first, got_byte.last, got_byte.err);
        end
      end
    end
  end

  initial begin
    logic [7:0]  kind;
    logic [7:0]  noise;
    logic [15:0] len;
    int          sel;

    // Directed table: unknown types, header-only packets, short bodies, type codes in a body.
    dir_tab[0]  = mk_row(8'h00, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[1]  = mk_row(8'hFF, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[2]  = mk_row(8'hC0, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[3]  = mk_row(TYPE_SHORT_A, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[4]  = mk_row(8'h02, 1'b1, 2'd2, mk_byte(TYPE_SHORT_A, 1'b1, 1'b0, 1'b0),
                         mk_byte(8'h02, 1'b0, 1'b1, 1'b0), NoByte);
    dir_tab[5]  = mk_row(TYPE_SHORT_B, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[6]  = mk_row(8'h03, 1'b1, 2'd2, mk_byte(TYPE_SHORT_B, 1'b1, 1'b0, 1'b0),
                         mk_byte(8'h03, 1'b0, 1'b0, 1'b0), NoByte);
    dir_tab[7]  = mk_row(8'hFF, 1'b1, 2'd1, mk_byte(8'hFF, 1'b0, 1'b1, 1'b0), NoByte, NoByte);
    dir_tab[8]  = mk_row(TYPE_LONG_A, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[9]  = mk_row(8'h00, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[10] = mk_row(8'h03, 1'b1, 2'd3, mk_byte(TYPE_LONG_A, 1'b1, 1'b0, 1'b0),
                         mk_byte(8'h00, 1'b0, 1'b0, 1'b0), mk_byte(8'h03, 1'b0, 1'b1, 1'b0));
    dir_tab[11] = mk_row(TYPE_LONG_B, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[12] = mk_row(8'h00, 1'b1, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[13] = mk_row(8'h05, 1'b1, 2'd3, mk_byte(TYPE_LONG_B, 1'b1, 1'b0, 1'b0),
                         mk_byte(8'h00, 1'b0, 1'b0, 1'b0), mk_byte(8'h05, 1'b0, 1'b0, 1'b0));
    dir_tab[14] = mk_row(8'h00, 1'b1, 2'd1, mk_byte(8'h00, 1'b0, 1'b0, 1'b0), NoByte, NoByte);
    dir_tab[15] = mk_row(TYPE_SHORT_A, 1'b1, 2'd1, mk_byte(TYPE_SHORT_A, 1'b0, 1'b1, 1'b0),
                         NoByte, NoByte);
    dir_tab[16] = mk_row(TYPE_SHORT_B, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[17] = mk_row(8'h04, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[18] = mk_row(8'h55, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[19] = mk_row(8'hAA, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[20] = mk_row(TYPE_LONG_B, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[21] = mk_row(8'h00, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[22] = mk_row(8'h04, 1'b0, 2'd0, NoByte, NoByte, NoByte);
    dir_tab[23] = mk_row(8'h7E, 1'b0, 2'd0, NoByte, NoByte, NoByte);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_row(dir_tab[i]);
    wait_drained();

    // Random part: mostly well-formed packets of small size, some unknown type bytes between.
    // It leaves room for the closing bad-length sequence and the bytes dropped after it.
    while (items_sent < ItemsTarget - TailItems) begin
      if ($urandom_range(0, 9) == 0) begin
        do noise = $urandom_range(0, 255);
        while (noise == TYPE_SHORT_A || noise == TYPE_SHORT_B ||
               noise == TYPE_LONG_A || noise == TYPE_LONG_B);
        send_byte(noise);
      end else begin
        kind = pick_type($urandom_range(0, 3));
        sel  = $urandom_range(0, 9);
        if (kind == TYPE_SHORT_A || kind == TYPE_SHORT_B) begin
          len = (sel == 0) ? 16'd2 : 16'($urandom_range(3, 16));
        end else begin
          len = (sel == 0) ? 16'd3 : 16'($urandom_range(4, 16));
        end
        send_packet(kind, len);
        if ($urandom_range(0, 11) == 0) wait_drained();
      end
    end

    // A bad length kills the stream, so it comes last, followed by bytes that must vanish.
    if ($urandom_range(0, 1) == 0) begin
      send_byte(pick_type($urandom_range(0, 1)));
      send_byte($urandom_range(0, 1));
    end else begin
      send_byte(pick_type($urandom_range(2, 3)));
      send_byte(8'h00);
      send_byte($urandom_range(0, 2));
    end
    repeat (8) send_byte(pick_type($urandom_range(0, 3)));
    repeat (8) send_byte($urandom_range(0, 255));

    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ length_prefixed_packet_deframer_unit.f @@
design/lppd_pkg.sv
design/lppd_parser.sv
design/lppd_outq.sv
design/length_prefixed_packet_deframer_unit.sv
test/length_prefixed_packet_deframer_unit_tb.sv
